### design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame deframer package
// Shared constants and the control struct that steers the cell chain.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'hAA;
    localparam logic [7:0]  FUNC_BYTE  = 8'hF1;
    localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
    localparam int          DATA_START = 3;
    localparam int          IDX_W      = 4;
    localparam int          COUNT_W    = 7;

    typedef struct packed {
        logic cap_shift;
        logic drn_load;
        logic drn_shift;
    } cell_ctl_t;

endpackage

### design/sfd_if.sv
// ----------------------------------------------------------------------------
// Sensor frame deframer channels
// Valid/ready channels for received bytes and for decoded words.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_word_if;
    logic                         valid;
    logic                         ready;
    logic [31:0]                  word;
    logic [sfd_pkg::IDX_W-1:0]    word_index;
    logic                         last;

    modport source (output valid, output word, output word_index, output last, input ready);
    modport sink (input valid, input word, input word_index, input last, output ready);
endinterface

### design/sfd_cell.sv
// ----------------------------------------------------------------------------
// Sensor frame deframer word cell
// Holds one word of the frame being captured and one word waiting to drain.
// ----------------------------------------------------------------------------
module sfd_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::cell_ctl_t ctl,
    input  logic [31:0]        cap_in,
    output logic [31:0]        cap_out,
    input  logic [31:0]        drn_in,
    input  logic               drn_valid_in,
    output logic [31:0]        drn_out,
    output logic               drn_valid_out
);

    logic [31:0] cap_word_reg;
    logic [31:0] cap_word_next;
    logic [31:0] drn_word_reg;
    logic [31:0] drn_word_next;
    logic        drn_valid_reg;
    logic        drn_valid_next;

    always_comb
    begin
        cap_word_next  = cap_word_reg;
        if (ctl.cap_shift)
        begin
            cap_word_next = cap_in;
        end
        priority if (ctl.drn_load)
        begin
            drn_word_next  = cap_word_reg;
            drn_valid_next = 1'b1;
        end
        else if (ctl.drn_shift)
        begin
            drn_word_next  = drn_in;
            drn_valid_next = drn_valid_in;
        end
        else
        begin
            drn_word_next  = drn_word_reg;
            drn_valid_next = drn_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_word_reg <= cap_word_next;
        drn_word_reg <= drn_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drn_valid_reg <= 1'b0;
        end
        else
        begin
            drn_valid_reg <= drn_valid_next;
        end
    end

    assign cap_out       = cap_word_reg;
    assign drn_out       = drn_word_reg;
    assign drn_valid_out = drn_valid_reg;

endmodule

### design/sensor_frame_deframer.sv
// The first word of a good frame is offered in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle in; one word per cycle out of the cell chain while tx.ready is high.
// The checksum byte of a frame waits while words of the previous frame are still draining.
// Reset clears the hunt state and the drain valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sensor frame deframer
// Hunts for sync, collects a frame, checks it and emits its words big-endian, minus zero as zero.
// ----------------------------------------------------------------------------
module sensor_frame_deframer
#(
    parameter int WORDS = 15
)
(
    input  logic       clk,
    input  logic       rst_n,
    sfd_byte_if.sink   rx,
    sfd_word_if.source tx
);

    localparam int FRAME_LEN = 4 * WORDS + 4;
    localparam int IW        = sfd_pkg::IDX_W;
    localparam int CW        = sfd_pkg::COUNT_W;

    logic          collecting_reg;
    logic          collecting_next;
    logic [CW-1:0] byte_count_reg;
    logic [CW-1:0] byte_count_next;
    logic [7:0]    running_sum_reg;
    logic [7:0]    running_sum_next;
    logic          header_good_reg;
    logic          header_good_next;
    logic [23:0]   partial_word_reg;
    logic [23:0]   partial_word_next;
    logic [IW-1:0] word_index_reg;
    logic [IW-1:0] word_index_next;

    logic          at_checksum;
    logic          accept;
    logic          drain_busy;
    logic          word_done;
    logic [CW-1:0] data_pos;
    logic [31:0]   full_word;
    logic [31:0]   new_word;
    logic          frame_good;

    sfd_pkg::cell_ctl_t ctl;

    logic [31:0] cap_chain [0:WORDS];
    logic [31:0] drn_chain [0:WORDS];
    logic        vld_chain [0:WORDS];

    assign drain_busy  = vld_chain[WORDS];
    assign at_checksum = collecting_reg && (byte_count_reg == CW'(FRAME_LEN - 1));
    assign rx.ready    = !(at_checksum && drain_busy);
    assign accept      = rx.valid && rx.ready;
    assign data_pos    = byte_count_reg - CW'(sfd_pkg::DATA_START);
    assign full_word   = {partial_word_reg, rx.rx_byte};
    assign new_word    = (full_word == sfd_pkg::NEG_ZERO) ? 32'd0 : full_word;
    assign frame_good  = header_good_reg && (rx.rx_byte == running_sum_reg);
    assign word_done   = accept && collecting_reg && !at_checksum
                         && (byte_count_reg >= CW'(sfd_pkg::DATA_START))
                         && (data_pos[1:0] == 2'd3);

    always_comb
    begin
        collecting_next   = collecting_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        header_good_next  = header_good_reg;
        partial_word_next = partial_word_reg;
        if (accept)
        begin
            priority if (!collecting_reg)
            begin
                if (rx.rx_byte == sfd_pkg::SYNC_BYTE)
                begin
                    collecting_next   = 1'b1;
                    byte_count_next   = '0;
                    running_sum_next  = sfd_pkg::SYNC_BYTE;
                    header_good_next  = 1'b1;
                    partial_word_next = '0;
                end
            end
            else if (at_checksum)
            begin
                collecting_next = 1'b0;
                byte_count_next = '0;
            end
            else
            begin
                running_sum_next = running_sum_reg + rx.rx_byte;
                if (byte_count_reg == CW'(0) && rx.rx_byte != sfd_pkg::SYNC_BYTE)
                begin
                    header_good_next = 1'b0;
                end
                if (byte_count_reg == CW'(1) && rx.rx_byte != sfd_pkg::FUNC_BYTE)
                begin
                    header_good_next = 1'b0;
                end
                if (byte_count_reg >= CW'(sfd_pkg::DATA_START))
                begin
                    if (data_pos[1:0] == 2'd3)
                    begin
                        partial_word_next = '0;
                    end
                    else
                    begin
                        partial_word_next = {partial_word_reg[15:0], rx.rx_byte};
                    end
                end
                byte_count_next = byte_count_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        word_index_next = word_index_reg;
        if (tx.valid && tx.ready)
        begin
            if (word_index_reg == IW'(WORDS - 1))
            begin
                word_index_next = '0;
            end
            else
            begin
                word_index_next = word_index_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg   <= 1'b0;
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
            header_good_reg  <= 1'b0;
            partial_word_reg <= '0;
            word_index_reg   <= '0;
        end
        else
        begin
            collecting_reg   <= collecting_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            header_good_reg  <= header_good_next;
            partial_word_reg <= partial_word_next;
            word_index_reg   <= word_index_next;
        end
    end

    assign ctl.cap_shift = word_done;
    assign ctl.drn_load  = accept && at_checksum && frame_good;
    assign ctl.drn_shift = tx.valid && tx.ready;

    assign cap_chain[0] = new_word;
    assign drn_chain[0] = '0;
    assign vld_chain[0] = 1'b0;

    for (genvar i = 0; i < WORDS; i++)
    begin : g_cell
        sfd_cell u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .cap_in        (cap_chain[i]),
            .cap_out       (cap_chain[i+1]),
            .drn_in        (drn_chain[i]),
            .drn_valid_in  (vld_chain[i]),
            .drn_out       (drn_chain[i+1]),
            .drn_valid_out (vld_chain[i+1])
        );
    end

    assign tx.valid      = vld_chain[WORDS];
    assign tx.word       = drn_chain[WORDS];
    assign tx.word_index = word_index_reg;
    assign tx.last       = (word_index_reg == IW'(WORDS - 1));

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame deframer testbench
// Streams received bytes into the deframer with random gaps and random output
// stalls. A behavioral decoder follows every accepted byte and queues the words
// that a good frame must produce, and each word transaction is checked field
// by field against that queue. Directed frames cover the hunt, extreme and
// minus zero words, sync bytes inside a frame, bad headers and bad checksums.
// A random stream of mostly well-formed frames and noise follows.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_WORDS    = 15;
    localparam int FRAME_BODY   = 4 * NUM_WORDS + 3;
    localparam int RANDOM_ITEMS = 80;
    localparam int STALL_MAX    = 17;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_MAX    = 50;

    typedef struct packed {
        logic [31:0]               word;
        logic [sfd_pkg::IDX_W-1:0] word_index;
        logic                      last;
    } frame_word_t;

    logic clk;
    logic rst_n;

    sfd_byte_if rx();
    sfd_word_if tx();

    sensor_frame_deframer #(.WORDS(NUM_WORDS)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx),
        .tx(tx)
    );

    logic                        in_frame;
    logic [sfd_pkg::COUNT_W-1:0] frame_pos;
    logic [7:0]                  frame_sum;
    logic                        header_ok;
    logic [23:0]                 word_bytes;
    logic [31:0]                 frame_words [NUM_WORDS];

    frame_word_t pending_words [$];
    logic [7:0]  frame_body [FRAME_BODY];

    int error_count;
    int bytes_sent;
    int words_checked;
    int good_frames;
    int dropped_frames;
    int idle_cycles;
    bit idle_on;
    bit moved;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_MAX)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int d;
        frame_word_t w;
        if (!in_frame)
        begin
            if (b == sfd_pkg::SYNC_BYTE)
            begin
                in_frame   = 1'b1;
                frame_pos  = '0;
                frame_sum  = sfd_pkg::SYNC_BYTE;
                header_ok  = 1'b1;
                word_bytes = '0;
            end
        end
        else if (frame_pos == FRAME_BODY)
        begin
            if (header_ok && b == frame_sum)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    w.word       = (frame_words[i] == sfd_pkg::NEG_ZERO) ? 32'h0
                                                                         : frame_words[i];
                    w.word_index = i[sfd_pkg::IDX_W-1:0];
                    w.last       = (i == NUM_WORDS - 1);
                    pending_words.push_back(w);
                end
                good_frames++;
            end
            else
            begin
                dropped_frames++;
            end
            in_frame  = 1'b0;
            frame_pos = '0;
        end
        else
        begin
            frame_sum = frame_sum + b;
            if (frame_pos == 0 && b != sfd_pkg::SYNC_BYTE)
            begin
                header_ok = 1'b0;
            end
            if (frame_pos == 1 && b != sfd_pkg::FUNC_BYTE)
            begin
                header_ok = 1'b0;
            end
            if (frame_pos >= sfd_pkg::DATA_START)
            begin
                d = int'(frame_pos) - sfd_pkg::DATA_START;
                if (d % 4 == 3)
                begin
                    frame_words[d / 4] = {word_bytes, b};
                    word_bytes         = '0;
                end
                else
                begin
                    word_bytes = {word_bytes[15:0], b};
                end
            end
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    task automatic check_word();
        frame_word_t w;
        if (pending_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h index %0d", tx.word, tx.word_index));
        end
        else
        begin
            w = pending_words.pop_front();
            if (tx.word !== w.word)
            begin
                report_mismatch($sformatf("word %h, expected %h", tx.word, w.word));
            end
            if (tx.word_index !== w.word_index)
            begin
                report_mismatch($sformatf("word_index %0d, expected %0d",
                    tx.word_index, w.word_index));
            end
            if (tx.last !== w.last)
            begin
                report_mismatch($sformatf("last %b, expected %b at index %0d",
                    tx.last, w.last, w.word_index));
            end
            words_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (rx.valid && rx.ready)
            begin
                decode_byte(rx.rx_byte);
                moved = 1'b1;
            end
            if (tx.valid && tx.ready)
            begin
                check_word();
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int stall;
        tx.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0)
            begin
                tx.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tx.ready <= 1'b1;
            @(posedge clk);
            while (!tx.valid) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        rx.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    task automatic set_word(input int idx, input logic [31:0] value);
        for (int k = 0; k < 4; k++)
        begin
            frame_body[sfd_pkg::DATA_START + 4 * idx + k] = value[31 - 8 * k -: 8];
        end
    endtask

    task automatic fill_body();
        frame_body[0] = sfd_pkg::SYNC_BYTE;
        frame_body[1] = sfd_pkg::FUNC_BYTE;
        for (int i = 2; i < FRAME_BODY; i++)
        begin
            frame_body[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                set_word(i, sfd_pkg::NEG_ZERO);
            end
        end
    endtask

    task automatic send_frame(input bit bad_sum);
        logic [7:0] sum;
        sum = sfd_pkg::SYNC_BYTE;
        send_byte(sfd_pkg::SYNC_BYTE);
        for (int i = 0; i < FRAME_BODY; i++)
        begin
            sum = sum + frame_body[i];
            send_byte(frame_body[i]);
        end
        if (bad_sum)
        begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        send_byte(sum);
    endtask

    task automatic test_hunt_noise();
        idle_on = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(sfd_pkg::FUNC_BYTE);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
    endtask

    task automatic test_extreme_words();
        fill_body();
        frame_body[2] = 8'h00;
        set_word(0, 32'h0000_0000);
        set_word(1, 32'hFFFF_FFFF);
        set_word(2, sfd_pkg::NEG_ZERO);
        set_word(3, 32'h7FFF_FFFF);
        set_word(4, 32'h8000_0001);
        set_word(5, 32'h0000_0080);
        set_word(NUM_WORDS - 1, sfd_pkg::NEG_ZERO);
        send_frame(1'b0);
    endtask

    task automatic test_sync_inside_frame();
        fill_body();
        frame_body[2] = sfd_pkg::SYNC_BYTE;
        set_word(0, {4{sfd_pkg::SYNC_BYTE}});
        set_word(7, {sfd_pkg::SYNC_BYTE, sfd_pkg::FUNC_BYTE, sfd_pkg::SYNC_BYTE, 8'h00});
        send_frame(1'b0);
    endtask

    task automatic test_bad_checksum();
        fill_body();
        send_frame(1'b1);
    endtask

    task automatic test_bad_header();
        fill_body();
        frame_body[0] = 8'h55;
        send_frame(1'b0);
        fill_body();
        frame_body[1] = 8'hF2;
        send_frame(1'b0);
    endtask

    task automatic test_drain_pause();
        idle_on = 1'b0;
        fill_body();
        send_frame(1'b0);
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_stream();
        int start;
        int kind;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            if (kind < 6)
            begin
                fill_body();
                send_frame(1'b0);
            end
            else if (kind == 6)
            begin
                fill_body();
                n = $urandom_range(0, 1);
                frame_body[n] = frame_body[n] ^ 8'($urandom_range(1, 255));
                send_frame(1'b0);
            end
            else if (kind == 7)
            begin
                fill_body();
                send_frame(1'b1);
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(sfd_pkg::SYNC_BYTE);
                n = $urandom_range(1, 40);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        rx.valid    <= 1'b0;
        rx.rx_byte  <= 8'h00;
        in_frame     = 1'b0;
        frame_pos    = '0;
        frame_sum    = '0;
        header_ok    = 1'b0;
        word_bytes   = '0;
        error_count  = 0;
        bytes_sent   = 0;
        words_checked = 0;
        good_frames  = 0;
        dropped_frames = 0;
        idle_cycles  = 0;
        idle_on      = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunt_noise();
        test_extreme_words();
        test_sync_inside_frame();
        test_bad_checksum();
        test_bad_header();
        test_drain_pause();
        test_random_stream();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d good frames decoded, %0d frames dropped.",
            bytes_sent, good_frames, dropped_frames);
        $display("Checked %0d words under random input gaps and output stalls.",
            words_checked);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
